>>> rtl/mdx_pkg.sv
package mdx_pkg;

    localparam int NUM_CH      = 6;
    localparam int NUM_TERMS   = 3;
    localparam int SAMPLE_W    = 24;
    localparam int PCM_W       = 16;
    localparam int COEF_W      = 17;
    localparam int SEL_W       = 3;
    localparam int PROD_W      = COEF_W + 1 + SAMPLE_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int SCALE_SHIFT = 15;
    localparam int SCALED_W    = ACC_W + SCALE_SHIFT;
    localparam int FRAC_SHIFT  = 36;
    localparam int Q_W         = SCALED_W - FRAC_SHIFT;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PCM_W-1:0]    pcm_t;
    typedef logic [COEF_W-1:0]          coef_t;
    typedef logic [SEL_W-1:0]           sel_t;

    localparam coef_t COEF_FRONT = 17'd27145;
    localparam coef_t COEF_MONO  = 17'd46341;
    localparam coef_t COEF_UNITY = 17'd65536;

    localparam logic [PCM_W-1:0] PCM_MAX = {1'b0, {(PCM_W-1){1'b1}}};
    localparam logic [PCM_W-1:0] PCM_MIN = {1'b1, {(PCM_W-1){1'b0}}};

    localparam logic [2:0] OUT_COUNT_2 = 3'd2;
    localparam logic [2:0] OUT_COUNT_4 = 3'd4;
    localparam logic [2:0] OUT_COUNT_6 = 3'd6;

    typedef enum logic [2:0] {
        MODE_DUAL_MONO,
        MODE_MONO,
        MODE_STEREO,
        MODE_3_0,
        MODE_2_1,
        MODE_3_1,
        MODE_2_2,
        MODE_3_2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_MODE,
        REG_OUTPUT_COUNT,
        REG_CENTRE_LEVEL,
        REG_SURROUND_LEVEL,
        REG_LFE_ENABLE,
        REG_DUAL_MONO_SELECT
    } cfg_reg_t;

    typedef struct packed {
        coef_t coef;
        sel_t  sel;
    } term_t;

    typedef struct packed {
        term_t [NUM_CH-1:0][NUM_TERMS-1:0] term;
        logic                              err;
    } plan_t;

    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0]             frame_t;
    typedef logic [NUM_CH-1:0][NUM_TERMS-1:0][PROD_W-1:0] prod_frame_t;
    typedef logic [NUM_CH-1:0][ACC_W-1:0]                acc_frame_t;
    typedef logic [NUM_CH-1:0][PCM_W-1:0]                pcm_frame_t;

    function automatic coef_t centre_coef(input logic [1:0] code);
        coef_t c;
        case (code)
            2'd0:    c = 17'd19189;
            2'd1:    c = 17'd16174;
            2'd2:    c = 17'd13573;
            default: c = 17'd16174;
        endcase
        return c;
    endfunction

    function automatic coef_t surround_coef(input logic [1:0] code);
        coef_t c;
        case (code)
            2'd0:    c = 17'd19189;
            2'd1:    c = 17'd13573;
            2'd2:    c = 17'd0;
            default: c = 17'd13573;
        endcase
        return c;
    endfunction

    function automatic term_t mk_term(input coef_t coef, input sel_t sel);
        term_t t;
        t.coef = coef;
        t.sel  = sel;
        return t;
    endfunction

endpackage

>>> rtl/mdx_if.sv
interface mdx_in_if;
    import mdx_pkg::*;
    logic    valid;
    logic    ready;
    sample_t in_ch0;
    sample_t in_ch1;
    sample_t in_ch2;
    sample_t in_ch3;
    sample_t in_ch4;
    sample_t in_ch5;

    modport source (output valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5,
                    input ready);
    modport sink (input valid, in_ch0, in_ch1, in_ch2, in_ch3, in_ch4, in_ch5,
                  output ready);
endinterface

interface mdx_out_if;
    import mdx_pkg::*;
    logic valid;
    logic ready;
    pcm_t out_ch0;
    pcm_t out_ch1;
    pcm_t out_ch2;
    pcm_t out_ch3;
    pcm_t out_ch4;
    pcm_t out_ch5;
    logic mode_error;

    modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                    mode_error, input ready);
    modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
                  mode_error, output ready);
endinterface

interface mdx_cfg_if;
    import mdx_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/mdx_cfg.sv
module mdx_cfg (
    input  logic          clk,
    input  logic          rst_n,
    mdx_cfg_if.sink       cfg,
    output mdx_pkg::plan_t plan
);
    import mdx_pkg::*;

    mode_t      mode_reg;
    logic [2:0] count_reg;
    logic [1:0] centre_reg;
    logic [1:0] surround_reg;
    logic       lfe_reg;
    logic       dms_reg;
    coef_t      c_coef;
    coef_t      s_coef;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_STEREO;
            count_reg    <= OUT_COUNT_2;
            centre_reg   <= 2'd0;
            surround_reg <= 2'd0;
            lfe_reg      <= 1'b0;
            dms_reg      <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_CHANNEL_MODE:     mode_reg     <= mode_t'(cfg.data[2:0]);
                REG_OUTPUT_COUNT:     count_reg    <= cfg.data[2:0];
                REG_CENTRE_LEVEL:     centre_reg   <= cfg.data[1:0];
                REG_SURROUND_LEVEL:   surround_reg <= cfg.data[1:0];
                REG_LFE_ENABLE:       lfe_reg      <= cfg.data[0];
                REG_DUAL_MONO_SELECT: dms_reg      <= cfg.data[0];
                default:              ;
            endcase
        end
    end

    assign c_coef = centre_coef(centre_reg);
    assign s_coef = surround_coef(surround_reg);

    always_comb
    begin
        plan = '0;
        unique case (mode_reg)
            MODE_3_2:
            begin
                if (count_reg == OUT_COUNT_2)
                begin
                    plan.term[0][0] = mk_term(COEF_FRONT, 3'd0);
                    plan.term[0][1] = mk_term(c_coef, 3'd1);
                    plan.term[0][2] = mk_term(s_coef, 3'd3);
                    plan.term[1][0] = mk_term(COEF_FRONT, 3'd2);
                    plan.term[1][1] = mk_term(c_coef, 3'd1);
                    plan.term[1][2] = mk_term(s_coef, 3'd4);
                end
                else if (count_reg == OUT_COUNT_4)
                begin
                    plan.term[0][0] = mk_term(COEF_FRONT, 3'd0);
                    plan.term[0][1] = mk_term(c_coef, 3'd1);
                    plan.term[1][0] = mk_term(COEF_FRONT, 3'd2);
                    plan.term[1][1] = mk_term(c_coef, 3'd1);
                    plan.term[2][0] = mk_term(COEF_FRONT, 3'd3);
                    plan.term[3][0] = mk_term(COEF_FRONT, 3'd4);
                end
                else if (count_reg == OUT_COUNT_6)
                begin
                    plan.term[0][0] = mk_term(COEF_FRONT, 3'd0);
                    plan.term[1][0] = mk_term(COEF_FRONT, 3'd2);
                    plan.term[2][0] = mk_term(COEF_FRONT, 3'd3);
                    plan.term[3][0] = mk_term(COEF_FRONT, 3'd4);
                    plan.term[4][0] = mk_term(COEF_FRONT, 3'd1);
                    if (lfe_reg)
                    begin
                        plan.term[5][0] = mk_term(COEF_FRONT, 3'd5);
                    end
                end
                else
                begin
                    plan.err = 1'b1;
                end
            end
            MODE_2_2:
            begin
                if (count_reg == OUT_COUNT_2)
                begin
                    plan.term[0][0] = mk_term(COEF_FRONT, 3'd0);
                    plan.term[0][2] = mk_term(s_coef, 3'd2);
                    plan.term[1][0] = mk_term(COEF_FRONT, 3'd1);
                    plan.term[1][2] = mk_term(s_coef, 3'd3);
                end
                else
                begin
                    plan.err = 1'b1;
                end
            end
            MODE_3_1:
            begin
                if (count_reg == OUT_COUNT_2)
                begin
                    plan.term[0][0] = mk_term(COEF_FRONT, 3'd0);
                    plan.term[0][1] = mk_term(c_coef, 3'd1);
                    plan.term[0][2] = mk_term(s_coef, 3'd3);
                    plan.term[1][0] = mk_term(COEF_FRONT, 3'd2);
                    plan.term[1][1] = mk_term(c_coef, 3'd1);
                    plan.term[1][2] = mk_term(s_coef, 3'd3);
                end
                else
                begin
                    plan.err = 1'b1;
                end
            end
            MODE_2_1:
            begin
                if (count_reg == OUT_COUNT_2)
                begin
                    plan.term[0][0] = mk_term(COEF_FRONT, 3'd0);
                    plan.term[0][2] = mk_term(s_coef, 3'd2);
                    plan.term[1][0] = mk_term(COEF_FRONT, 3'd1);
                    plan.term[1][2] = mk_term(s_coef, 3'd2);
                end
                else
                begin
                    plan.err = 1'b1;
                end
            end
            MODE_3_0:
            begin
                if (count_reg == OUT_COUNT_2)
                begin
                    plan.term[0][0] = mk_term(COEF_FRONT, 3'd0);
                    plan.term[0][1] = mk_term(c_coef, 3'd1);
                    plan.term[1][0] = mk_term(COEF_FRONT, 3'd2);
                    plan.term[1][1] = mk_term(c_coef, 3'd1);
                end
                else
                begin
                    plan.err = 1'b1;
                end
            end
            MODE_STEREO:
            begin
                if (count_reg == OUT_COUNT_2 || count_reg == OUT_COUNT_6)
                begin
                    plan.term[0][0] = mk_term(COEF_UNITY, 3'd0);
                    plan.term[1][0] = mk_term(COEF_UNITY, 3'd1);
                end
                else
                begin
                    plan.err = 1'b1;
                end
            end
            MODE_MONO:
            begin
                if (count_reg == OUT_COUNT_2)
                begin
                    plan.term[0][0] = mk_term(COEF_MONO, 3'd0);
                    plan.term[1][0] = mk_term(COEF_MONO, 3'd0);
                end
                else
                begin
                    plan.err = 1'b1;
                end
            end
            MODE_DUAL_MONO:
            begin
                if (count_reg == OUT_COUNT_2)
                begin
                    plan.term[0][0] = mk_term(COEF_MONO, {2'b00, dms_reg});
                    plan.term[1][0] = mk_term(COEF_MONO, {2'b00, dms_reg});
                end
                else
                begin
                    plan.err = 1'b1;
                end
            end
        endcase
    end

endmodule

>>> rtl/mdx_mult.sv
module mdx_mult (
    input  logic                clk,
    input  logic                rst_n,
    mdx_in_if.sink              din,
    input  mdx_pkg::plan_t      plan,
    output logic                prod_valid,
    input  logic                prod_ready,
    output mdx_pkg::prod_frame_t prod
);
    import mdx_pkg::*;

    logic        x_valid_reg;
    frame_t      x_reg;
    logic        prod_valid_reg;
    prod_frame_t prod_reg;
    prod_frame_t prod_next;
    logic        x_ready;
    logic        prod_stage_ready;

    assign prod_stage_ready = !prod_valid_reg || prod_ready;
    assign x_ready          = !x_valid_reg || prod_stage_ready;
    assign din.ready        = x_ready;

    // hold a word at each stage until the next stage can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg    <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (x_ready)
            begin
                x_valid_reg <= din.valid;
            end
            if (prod_stage_ready)
            begin
                prod_valid_reg <= x_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_ready && din.valid)
        begin
            x_reg <= {din.in_ch5, din.in_ch4, din.in_ch3, din.in_ch2, din.in_ch1, din.in_ch0};
        end
        if (prod_stage_ready && x_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            for (int t = 0; t < NUM_TERMS; t++)
            begin
                prod_next[k][t] = $signed({1'b0, plan.term[k][t].coef})
                                  * $signed(x_reg[plan.term[k][t].sel]);
            end
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

>>> rtl/mdx_scale.sv
module mdx_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 prod_valid,
    output logic                 prod_ready,
    input  mdx_pkg::prod_frame_t prod,
    input  logic                 err,
    mdx_out_if.source            dout
);
    import mdx_pkg::*;

    logic       acc_valid_reg;
    acc_frame_t acc_reg;
    acc_frame_t acc_next;
    logic       out_valid_reg;
    pcm_frame_t out_reg;
    pcm_frame_t out_next;
    logic       err_reg;
    logic       acc_stage_ready;
    logic       out_stage_ready;

    function automatic logic [PCM_W-1:0] to_pcm(input logic signed [ACC_W-1:0] acc);
        logic signed [SCALED_W-1:0] p;
        logic [SCALED_W-1:0]        mag;
        logic [Q_W-1:0]             q;
        logic [PCM_W-1:0]           r;
        p   = (SCALED_W'(acc) <<< SCALE_SHIFT) - SCALED_W'(acc);
        mag = p[SCALED_W-1] ? $unsigned(-p) : $unsigned(p);
        q   = mag[SCALED_W-1:FRAC_SHIFT];
        if (p[SCALED_W-1])
        begin
            r = (q > Q_W'(PCM_MIN)) ? PCM_MIN : (~q[PCM_W-1:0] + PCM_W'(1));
        end
        else
        begin
            r = (q > Q_W'(PCM_MAX)) ? PCM_MAX : q[PCM_W-1:0];
        end
        return r;
    endfunction

    assign out_stage_ready = !out_valid_reg || dout.ready;
    assign acc_stage_ready = !acc_valid_reg || out_stage_ready;
    assign prod_ready      = acc_stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc_stage_ready)
            begin
                acc_valid_reg <= prod_valid;
            end
            if (out_stage_ready)
            begin
                out_valid_reg <= acc_valid_reg;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            acc_next[k] = ACC_W'($signed(prod[k][0])) + ACC_W'($signed(prod[k][1]))
                          + ACC_W'($signed(prod[k][2]));
            out_next[k] = err ? '0 : to_pcm($signed(acc_reg[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_stage_ready && prod_valid)
        begin
            acc_reg <= acc_next;
        end
        if (out_stage_ready && acc_valid_reg)
        begin
            out_reg <= out_next;
            err_reg <= err;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.out_ch0    = out_reg[0];
    assign dout.out_ch1    = out_reg[1];
    assign dout.out_ch2    = out_reg[2];
    assign dout.out_ch3    = out_reg[3];
    assign dout.out_ch4    = out_reg[4];
    assign dout.out_ch5    = out_reg[5];
    assign dout.mode_error = err_reg;

endmodule

>>> rtl/multichannel_audio_downmix.sv
// Six-channel to PCM downmix.
// Channels:
//   din  - one word per sample instant: six signed Q4.20 samples.
//   dout - one word per accepted input: six 16-bit PCM samples and mode_error.
//   cfg  - register writes (index, data); always ready, so each write is taken when valid.
// Throughput: one word per cycle while dout is ready; four registered stages (input, products,
//   sums, saturated PCM) each hand a word on as soon as the next one frees.
// Stall: when dout is not ready the output word holds and earlier stages keep
//   filling; din ready drops only when every stage holds a word.
// Reset: all stages empty; mode 2/0, two outputs, level codes 0, LFE off,
//   dual-mono pick 0. Change registers only with the pipeline drained.
// Unsupported mode/count pairs give mode_error set and zero PCM.
module multichannel_audio_downmix (
    input  logic      clk,
    input  logic      rst_n,
    mdx_cfg_if.sink   cfg,
    mdx_in_if.sink    din,
    mdx_out_if.source dout
);
    import mdx_pkg::*;

    plan_t       plan;
    logic        prod_valid;
    logic        prod_ready;
    prod_frame_t prod;

    mdx_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .plan  (plan)
    );

    mdx_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .plan       (plan),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    mdx_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .err        (plan.err),
        .dout       (dout)
    );

endmodule

>>> rtl/mdx_checker.sv
module mdx_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] out_ch0,
    input logic signed [15:0] out_ch1,
    input logic signed [15:0] out_ch2,
    input logic signed [15:0] out_ch3,
    input logic signed [15:0] out_ch4,
    input logic signed [15:0] out_ch5,
    input logic               mode_error
);

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_stall_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_stall_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_ch0) && $stable(out_ch1)
            && $stable(out_ch2) && $stable(out_ch3) && $stable(out_ch4)
            && $stable(out_ch5) && $stable(mode_error))
        else $error("output word changed while stalled");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_error |-> out_ch0 == 16'sd0 && out_ch1 == 16'sd0
            && out_ch2 == 16'sd0 && out_ch3 == 16'sd0 && out_ch4 == 16'sd0
            && out_ch5 == 16'sd0)
        else $error("nonzero PCM with mode error");

endmodule

bind multichannel_audio_downmix mdx_checker u_mdx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_ch0    (dout.out_ch0),
    .out_ch1    (dout.out_ch1),
    .out_ch2    (dout.out_ch2),
    .out_ch3    (dout.out_ch3),
    .out_ch4    (dout.out_ch4),
    .out_ch5    (dout.out_ch5),
    .mode_error (dout.mode_error)
);

>>> tb/multichannel_audio_downmix_test.sv
module multichannel_audio_downmix_test;
    import mdx_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  IDLE_PCT     = 22;
    localparam int  PHASES       = 16;
    localparam int  PHASE_WORDS  = 60;
    localparam int  HOLD_CYCLES  = 80;
    localparam longint PCM_SCALE = 32767;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef sample_t chans_t [NUM_CH];

    typedef struct packed {
        logic [NUM_CH-1:0][PCM_W-1:0] pcm;
        logic                         err;
    } mix_result_t;

    logic clk = 1'b0;
    logic rst_n;

    mdx_cfg_if cfg_if ();
    mdx_in_if  din_if ();
    mdx_out_if dout_if ();

    multichannel_audio_downmix u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .din   (din_if),
        .dout  (dout_if)
    );

    mode_t      mode_reg;
    logic [2:0] count_reg;
    logic [1:0] clev_reg;
    logic [1:0] slev_reg;
    logic       lfe_reg;
    logic       dsel_reg;

    mix_result_t pending_mix [$];
    int          mismatches   = 0;
    int          frames_sent  = 0;
    int          frames_seen  = 0;
    int          settings_used = 0;
    int          cycles       = 0;
    int          hold_req     = 0;
    int          hold_left    = 0;
    bit          src_gaps     = 1'b1;
    bit          sink_stalls  = 1'b1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d words still pending", $time, pending_mix.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [PCM_W-1:0] pcm_of(input longint acc);
        longint          p;
        longint unsigned mag;
        longint unsigned q;
        logic [PCM_W-1:0] r;
        p   = acc * PCM_SCALE;
        mag = (p < 0) ? -p : p;
        q   = mag >> FRAC_SHIFT;
        if (p < 0)
            r = (q > 32768) ? PCM_MIN : PCM_W'(-longint'(q));
        else
            r = (q > 32767) ? PCM_MAX : PCM_W'(q);
        return r;
    endfunction

    function automatic mix_result_t mix_frame(input chans_t s);
        longint      x [NUM_CH];
        longint      acc [NUM_CH];
        longint      a;
        longint      c;
        longint      v;
        logic        err;
        mix_result_t r;
        a   = longint'(COEF_FRONT);
        err = 1'b0;
        case (clev_reg)
            2'd0:    c = 19189;
            2'd1:    c = 16174;
            2'd2:    c = 13573;
            default: c = 16174;
        endcase
        case (slev_reg)
            2'd0:    v = 19189;
            2'd1:    v = 13573;
            2'd2:    v = 0;
            default: v = 13573;
        endcase
        for (int i = 0; i < NUM_CH; i++)
        begin
            x[i]   = s[i];
            acc[i] = 0;
        end
        case (mode_reg)
            MODE_3_2:
                if (count_reg == OUT_COUNT_2)
                begin
                    acc[0] = a * x[0] + c * x[1] + v * x[3];
                    acc[1] = a * x[2] + c * x[1] + v * x[4];
                end
                else if (count_reg == OUT_COUNT_4)
                begin
                    acc[0] = a * x[0] + c * x[1];
                    acc[1] = a * x[2] + c * x[1];
                    acc[2] = a * x[3];
                    acc[3] = a * x[4];
                end
                else if (count_reg == OUT_COUNT_6)
                begin
                    acc[0] = a * x[0];
                    acc[1] = a * x[2];
                    acc[2] = a * x[3];
                    acc[3] = a * x[4];
                    acc[4] = a * x[1];
                    acc[5] = lfe_reg ? a * x[5] : 0;
                end
                else
                    err = 1'b1;
            MODE_2_2:
                if (count_reg == OUT_COUNT_2)
                begin
                    acc[0] = a * x[0] + v * x[2];
                    acc[1] = a * x[1] + v * x[3];
                end
                else
                    err = 1'b1;
            MODE_3_1:
                if (count_reg == OUT_COUNT_2)
                begin
                    acc[0] = a * x[0] + c * x[1] + v * x[3];
                    acc[1] = a * x[2] + c * x[1] + v * x[3];
                end
                else
                    err = 1'b1;
            MODE_2_1:
                if (count_reg == OUT_COUNT_2)
                begin
                    acc[0] = a * x[0] + v * x[2];
                    acc[1] = a * x[1] + v * x[2];
                end
                else
                    err = 1'b1;
            MODE_3_0:
                if (count_reg == OUT_COUNT_2)
                begin
                    acc[0] = a * x[0] + c * x[1];
                    acc[1] = a * x[2] + c * x[1];
                end
                else
                    err = 1'b1;
            MODE_STEREO:
                if (count_reg == OUT_COUNT_2 || count_reg == OUT_COUNT_6)
                begin
                    acc[0] = longint'(COEF_UNITY) * x[0];
                    acc[1] = longint'(COEF_UNITY) * x[1];
                end
                else
                    err = 1'b1;
            MODE_MONO:
                if (count_reg == OUT_COUNT_2)
                begin
                    acc[0] = longint'(COEF_MONO) * x[0];
                    acc[1] = acc[0];
                end
                else
                    err = 1'b1;
            default:
                if (count_reg == OUT_COUNT_2)
                begin
                    acc[0] = longint'(COEF_MONO) * x[dsel_reg];
                    acc[1] = acc[0];
                end
                else
                    err = 1'b1;
        endcase
        for (int i = 0; i < NUM_CH; i++)
            r.pcm[i] = err ? '0 : pcm_of(acc[i]);
        r.err = err;
        return r;
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 3))
            0:       return sample_t'($urandom);
            1, 2:    return sample_t'(int'($urandom_range(0, 2097151)) - 1048576);
            default: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        endcase
    endfunction

    function automatic chans_t edge_frame(input int k);
        chans_t f;
        for (int i = 0; i < NUM_CH; i++)
            case (k % 4)
                0:       f[i] = SAMPLE_MAX;
                1:       f[i] = SAMPLE_MIN;
                2:       f[i] = (i % 2 == 1) ? SAMPLE_MIN : SAMPLE_MAX;
                default: f[i] = sample_t'((i - 2) * 262144);
            endcase
        return f;
    endfunction

    function automatic chans_t rand_frame();
        chans_t f;
        for (int i = 0; i < NUM_CH; i++)
            f[i] = rand_sample();
        return f;
    endfunction

    // keep valid high across back-to-back words; drop it only for a gap
    task automatic send_frame(input chans_t f);
        if (src_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
        end
        din_if.valid  <= 1'b1;
        din_if.in_ch0 <= f[0];
        din_if.in_ch1 <= f[1];
        din_if.in_ch2 <= f[2];
        din_if.in_ch3 <= f[3];
        din_if.in_ch4 <= f[4];
        din_if.in_ch5 <= f[5];
        do @(posedge clk); while (!din_if.ready);
        pending_mix.push_back(mix_frame(f));
        frames_sent++;
    endtask

    task automatic wait_drained();
        din_if.valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            REG_CHANNEL_MODE:     mode_reg  = mode_t'(val[2:0]);
            REG_OUTPUT_COUNT:     count_reg = val[2:0];
            REG_CENTRE_LEVEL:     clev_reg  = val[1:0];
            REG_SURROUND_LEVEL:   slev_reg  = val[1:0];
            REG_LFE_ENABLE:       lfe_reg   = val[0];
            REG_DUAL_MONO_SELECT: dsel_reg  = val[0];
            default: ;
        endcase
    endtask

    // wide: fill the unused upper bits and poke the spare indexes too
    task automatic set_config(input mode_t m, input logic [2:0] n, input logic [1:0] cl,
                              input logic [1:0] sl, input logic le, input logic ds,
                              input bit wide);
        logic [CFG_DATA_W-1:0] pad;
        wait_drained();
        pad = wide ? CFG_DATA_W'($urandom) : '0;
        cfg_write(REG_CHANNEL_MODE,     {pad[CFG_DATA_W-1:3], m});
        cfg_write(REG_OUTPUT_COUNT,     {pad[CFG_DATA_W-1:3], n});
        cfg_write(REG_CENTRE_LEVEL,     {pad[CFG_DATA_W-1:2], cl});
        cfg_write(REG_SURROUND_LEVEL,   {pad[CFG_DATA_W-1:2], sl});
        cfg_write(REG_LFE_ENABLE,       {pad[CFG_DATA_W-1:1], le});
        cfg_write(REG_DUAL_MONO_SELECT, {pad[CFG_DATA_W-1:1], ds});
        if (wide)
        begin
            cfg_write(REG_SPARE_6, CFG_DATA_W'($urandom));
            cfg_write(REG_SPARE_7, CFG_DATA_W'($urandom));
        end
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            dout_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req > 0)
        begin
            dout_if.ready <= 1'b0;
            hold_left = hold_req - 1;
            hold_req  = 0;
        end
        else
            dout_if.ready <= !(sink_stalls && $urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_mix
        mix_result_t got;
        mix_result_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            got.pcm[0] = dout_if.out_ch0;
            got.pcm[1] = dout_if.out_ch1;
            got.pcm[2] = dout_if.out_ch2;
            got.pcm[3] = dout_if.out_ch3;
            got.pcm[4] = dout_if.out_ch4;
            got.pcm[5] = dout_if.out_ch5;
            got.err    = dout_if.mode_error;
            frames_seen++;
            if (pending_mix.size() == 0)
                note_mismatch("unexpected word, mode_error", -1, got.err);
            else
            begin
                want = pending_mix.pop_front();
                for (int i = 0; i < NUM_CH; i++)
                    if (got.pcm[i] !== want.pcm[i])
                        note_mismatch($sformatf("out_ch%0d", i),
                                      $signed(want.pcm[i]), $signed(got.pcm[i]));
                if (got.err !== want.err)
                    note_mismatch("mode_error", want.err, got.err);
            end
        end
    end

    task automatic test_reset_state();
        send_frame(edge_frame(0));
        send_frame(edge_frame(1));
    endtask

    task automatic test_each_mode();
        for (int m = 0; m < 8; m++)
        begin
            set_config(mode_t'(m), OUT_COUNT_2, 2'(m), 2'(m + 1), 1'b0, m == 0, 1'b0);
            send_frame(edge_frame(m));
        end
    endtask

    task automatic test_wide_outputs();
        set_config(MODE_3_2, OUT_COUNT_4, 2'd1, 2'd1, 1'b0, 1'b0, 1'b0);
        send_frame(edge_frame(0));
        set_config(MODE_3_2, OUT_COUNT_6, 2'd2, 2'd0, 1'b1, 1'b0, 1'b0);
        send_frame(edge_frame(1));
        set_config(MODE_3_2, OUT_COUNT_6, 2'd0, 2'd3, 1'b0, 1'b0, 1'b0);
        send_frame(edge_frame(2));
        set_config(MODE_STEREO, OUT_COUNT_6, 2'd0, 2'd0, 1'b1, 1'b1, 1'b0);
        send_frame(edge_frame(3));
    endtask

    task automatic test_unsupported_pairs();
        set_config(MODE_3_0, OUT_COUNT_4, 2'd3, 2'd3, 1'b1, 1'b1, 1'b0);
        send_frame(edge_frame(0));
        set_config(MODE_3_2, 3'd3, 2'd0, 2'd0, 1'b1, 1'b0, 1'b0);
        send_frame(edge_frame(2));
        set_config(MODE_3_2, 3'd0, 2'd1, 2'd2, 1'b0, 1'b0, 1'b0);
        send_frame(edge_frame(1));
        set_config(MODE_MONO, OUT_COUNT_6, 2'd0, 2'd0, 1'b0, 1'b0, 1'b0);
        send_frame(edge_frame(3));
    endtask

    task automatic test_register_width();
        set_config(MODE_DUAL_MONO, OUT_COUNT_2, 2'd3, 2'd3, 1'b1, 1'b0, 1'b1);
        send_frame(edge_frame(3));
        set_config(MODE_2_2, OUT_COUNT_2, 2'd2, 2'd2, 1'b0, 1'b1, 1'b1);
        send_frame(edge_frame(2));
    endtask

    // hold the output long enough for every stage to fill and din to stall
    task automatic test_backpressure();
        set_config(MODE_3_2, OUT_COUNT_2, 2'd1, 2'd3, 1'b0, 1'b0, 1'b0);
        hold_req = HOLD_CYCLES;
        repeat (40) send_frame(rand_frame());
    endtask

    task automatic test_random_mix();
        logic [2:0] n;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_config(MODE_3_2, OUT_COUNT_6, 2'd3, 2'd3, 1'b1, 1'b1, 1'b0);
                1: set_config(MODE_DUAL_MONO, OUT_COUNT_2, 2'd0, 2'd0, 1'b0, 1'b0, 1'b0);
                default:
                begin
                    n = ($urandom_range(0, 9) < 6) ? OUT_COUNT_2 : 3'($urandom_range(0, 7));
                    set_config(mode_t'($urandom_range(0, 7)), n, 2'($urandom), 2'($urandom),
                               1'($urandom), 1'($urandom), 1'($urandom));
                end
            endcase
            src_gaps    = (ph != 3);
            sink_stalls = (ph != 3);
            repeat (PHASE_WORDS) send_frame(rand_frame());
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        din_if.valid   = 1'b0;
        din_if.in_ch0  = '0;
        din_if.in_ch1  = '0;
        din_if.in_ch2  = '0;
        din_if.in_ch3  = '0;
        din_if.in_ch4  = '0;
        din_if.in_ch5  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        dout_if.ready  = 1'b0;
        mode_reg       = MODE_STEREO;
        count_reg      = OUT_COUNT_2;
        clev_reg       = '0;
        slev_reg       = '0;
        lfe_reg        = 1'b0;
        dsel_reg       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_each_mode();
        test_wide_outputs();
        test_unsupported_pairs();
        test_register_width();
        test_backpressure();
        test_random_mix();
        wait_drained();

        $display("Sent %0d frames, checked %0d words over %0d register settings.",
                 frames_sent, frames_seen, settings_used);
        $display("Covered all channel modes, 2/4/6 outputs, bad pairs, saturation, long stall.");
        if (mismatches == 0 && pending_mix.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
